[rtl/bos_pkg.sv]
// bos_pkg: shared types and constants for the box overlap suppression core.
// No dependencies; used by bos_iou and box_overlap_suppression_core.
package bos_pkg;

	localparam int          FRAC_BITS    = 16;
	localparam int          THRESH_BITS  = 16;
	localparam logic [15:0] THRESH_RESET = 16'd52429;

	typedef struct packed {
		logic start;
	} iou_req_t;

	typedef struct packed {
		logic done;
		logic overlap;
	} iou_rsp_t;

endpackage

[rtl/bos_if.sv]
// bos_if: valid/ready channel interfaces for box requests and results.
// No dependencies.
interface bos_box_if #(
	parameter int COORD_BITS = 12,
	parameter int SCORE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] box_left;
	logic [COORD_BITS-1:0] box_top;
	logic [COORD_BITS-1:0] box_right;
	logic [COORD_BITS-1:0] box_bottom;
	logic [SCORE_BITS-1:0] score;
	logic                  final_box;

	modport source (output valid, box_left, box_top, box_right, box_bottom, score, final_box,
		input ready);
	modport sink (input valid, box_left, box_top, box_right, box_bottom, score, final_box,
		output ready);
endinterface

interface bos_res_if #(
	parameter int INDEX_BITS = 6,
	parameter int COORD_BITS = 12,
	parameter int SCORE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] arrival_index;
	logic [COORD_BITS-1:0] out_left;
	logic [COORD_BITS-1:0] out_top;
	logic [COORD_BITS-1:0] out_right;
	logic [COORD_BITS-1:0] out_bottom;
	logic [SCORE_BITS-1:0] out_score;
	logic                  kept;
	logic                  end_of_set;
	logic                  overflowed;

	modport source (output valid, arrival_index, out_left, out_top, out_right, out_bottom,
		out_score, kept, end_of_set, overflowed, input ready);
	modport sink (input valid, arrival_index, out_left, out_top, out_right, out_bottom,
		out_score, kept, end_of_set, overflowed, output ready);
endinterface

[rtl/box_overlap_suppression_core.sv]
// box_overlap_suppression_core: greedy IoU non-maximum suppression top level.
// Depends on bos_pkg, bos_if, bos_ram, bos_iou.
//
// Boxes are taken one request at a time into a MAX_BOXES-entry store until a
// request with final_box set closes the set; requests beyond capacity are
// dropped and the set is flagged overflowed. The block then stops taking
// requests while it ranks the boxes (descending score, ties in arrival
// order), runs the greedy overlap test against every earlier kept box, and
// emits one result per stored box in ranked order with kept, end_of_set and
// overflowed. Loading takes one box per cycle while requests are offered.
// Ranking reads the store once per compare; suppression runs the shared
// multiplier in bos_iou, up to six steps per pair, for each earlier box
// that was kept, and stops at the first overlap; emission holds each
// result until the result side takes it. The stores need no clearing pass:
// only entries written in the current set are read.
module box_overlap_suppression_core #(
	parameter int MAX_BOXES  = 64,
	parameter int COORD_BITS = 12,
	parameter int SCORE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bos_pkg::THRESH_BITS-1:0] cfg_wdata,
	bos_box_if.sink                         box_in,
	bos_res_if.source                       result_out
);
	localparam int IW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int CB = COORD_BITS;
	localparam int SB = SCORE_BITS;
	localparam int BW = 4 * CB + SB;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BOXES);
	localparam logic [CW-1:0] ONE     = CW'(1);

	typedef enum logic [17:0] {
		S_LOAD = 18'h00001,
		S_RK_A = 18'h00002, // read candidate box
		S_RK_B = 18'h00004, // latch its score
		S_RK_C = 18'h00008, // read comparison box
		S_RK_D = 18'h00010, // compare, count rank
		S_RK_W = 18'h00020, // place candidate at its rank
		S_SP_A = 18'h00040, // read order entry i
		S_SP_B = 18'h00080, // read current box
		S_SP_C = 18'h00100, // latch current box
		S_SP_D = 18'h00200, // read order/kept entry j
		S_SP_E = 18'h00400, // read box j
		S_SP_F = 18'h00800, // start pair test if j kept
		S_SP_G = 18'h01000, // wait for pair test
		S_SP_W = 18'h02000, // record kept flag of i
		S_EM_A = 18'h04000,
		S_EM_B = 18'h08000,
		S_EM_C = 18'h10000,
		S_EM_D = 18'h20000  // result held until taken
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q, k_q, m_q, rank_q, i_q, j_q;
	logic          ovf_q;
	logic [bos_pkg::THRESH_BITS-1:0] thr_q;
	logic [SB-1:0] score_k_q;
	logic [BW-1:0] cur_q;
	logic          kept_j_q, keep_q;
	logic [IW-1:0] idx_q;
	logic          kept_res_q;

	// result register
	logic [IW-1:0] res_idx_q;
	logic [BW-1:0] res_box_q;
	logic          res_kept_q, res_end_q, res_ovf_q;

	// store ports
	logic          box_we, ord_we, kept_we;
	logic [IW-1:0] box_raddr, ord_raddr, kept_raddr;
	logic [BW-1:0] box_rdata;
	logic [IW-1:0] ord_rdata;
	logic          kept_rdata;

	bos_pkg::iou_req_t iou_req;
	bos_pkg::iou_rsp_t iou_rsp;

	logic          take;
	logic [SB-1:0] rd_score;
	logic          beats;

	assign take     = box_in.valid && box_in.ready;
	assign rd_score = box_rdata[SB-1:0];
	assign beats    = (rd_score > score_k_q) || (rd_score == score_k_q && m_q < k_q);

	assign box_we  = take && (cnt_q < MAX_CNT);
	assign ord_we  = (state_q == S_RK_W);
	assign kept_we = (state_q == S_SP_W);
	assign iou_req.start = (state_q == S_SP_F) && kept_j_q;

	always_comb begin
		box_raddr = k_q[IW-1:0];
		case (state_q)
			S_RK_C: box_raddr = m_q[IW-1:0];
			S_SP_B, S_SP_E, S_EM_B: box_raddr = ord_rdata;
			default: ;
		endcase
	end

	always_comb begin
		ord_raddr  = i_q[IW-1:0];
		kept_raddr = i_q[IW-1:0];
		case (state_q)
			S_SP_D: begin
				ord_raddr  = j_q[IW-1:0];
				kept_raddr = j_q[IW-1:0];
			end
			default: ;
		endcase
	end

	bos_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_box_ram (
		.clk   (clk),
		.we    (box_we),
		.waddr (cnt_q[IW-1:0]),
		.wdata ({box_in.box_left, box_in.box_top, box_in.box_right, box_in.box_bottom,
			box_in.score}),
		.raddr (box_raddr),
		.rdata (box_rdata)
	);

	bos_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (rank_q[IW-1:0]),
		.wdata (k_q[IW-1:0]),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	bos_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_kept_ram (
		.clk   (clk),
		.we    (kept_we),
		.waddr (i_q[IW-1:0]),
		.wdata (keep_q),
		.raddr (kept_raddr),
		.rdata (kept_rdata)
	);

	bos_iou #(.COORD_BITS(CB)) u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iou_req),
		.box_a  (cur_q[BW-1:SB]),
		.box_b  (box_rdata[BW-1:SB]),
		.thresh (thr_q),
		.rsp    (iou_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bos_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_RK_B: score_k_q <= rd_score;
			S_SP_C: cur_q <= box_rdata;
			S_SP_E: kept_j_q <= kept_rdata;
			S_EM_B: begin
				idx_q      <= ord_rdata;
				kept_res_q <= kept_rdata;
			end
			S_EM_C: begin
				res_idx_q  <= idx_q;
				res_box_q  <= box_rdata;
				res_kept_q <= kept_res_q;
				res_end_q  <= (i_q == cnt_q - ONE);
				res_ovf_q  <= ovf_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
			m_q     <= '0;
			rank_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			keep_q  <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: if (take) begin
					if (cnt_q < MAX_CNT) cnt_q <= cnt_q + ONE;
					else ovf_q <= 1'b1;
					if (box_in.final_box) begin
						k_q     <= '0;
						state_q <= S_RK_A;
					end
				end
				S_RK_A: state_q <= S_RK_B;
				S_RK_B: begin
					m_q     <= '0;
					rank_q  <= '0;
					state_q <= S_RK_C;
				end
				S_RK_C: state_q <= S_RK_D;
				S_RK_D: begin
					if (beats) rank_q <= rank_q + ONE;
					if (m_q == cnt_q - ONE) state_q <= S_RK_W;
					else begin
						m_q     <= m_q + ONE;
						state_q <= S_RK_C;
					end
				end
				S_RK_W: begin
					if (k_q == cnt_q - ONE) begin
						i_q     <= '0;
						state_q <= S_SP_A;
					end else begin
						k_q     <= k_q + ONE;
						state_q <= S_RK_A;
					end
				end
				S_SP_A: state_q <= S_SP_B;
				S_SP_B: state_q <= S_SP_C;
				S_SP_C: begin
					j_q     <= '0;
					keep_q  <= 1'b1;
					state_q <= (i_q == '0) ? S_SP_W : S_SP_D;
				end
				S_SP_D: state_q <= S_SP_E;
				S_SP_E: state_q <= S_SP_F;
				S_SP_F: begin
					if (kept_j_q) state_q <= S_SP_G;
					else if (j_q + ONE == i_q) state_q <= S_SP_W;
					else begin
						j_q     <= j_q + ONE;
						state_q <= S_SP_D;
					end
				end
				S_SP_G: if (iou_rsp.done) begin
					if (iou_rsp.overlap) begin
						keep_q  <= 1'b0;
						state_q <= S_SP_W;
					end else if (j_q + ONE == i_q) state_q <= S_SP_W;
					else begin
						j_q     <= j_q + ONE;
						state_q <= S_SP_D;
					end
				end
				S_SP_W: begin
					if (i_q == cnt_q - ONE) begin
						i_q     <= '0;
						state_q <= S_EM_A;
					end else begin
						i_q     <= i_q + ONE;
						state_q <= S_SP_A;
					end
				end
				S_EM_A: state_q <= S_EM_B;
				S_EM_B: state_q <= S_EM_C;
				S_EM_C: state_q <= S_EM_D;
				S_EM_D: if (result_out.ready) begin
					if (i_q == cnt_q - ONE) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end else begin
						i_q     <= i_q + ONE;
						state_q <= S_EM_A;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign box_in.ready             = (state_q == S_LOAD);
	assign result_out.valid         = (state_q == S_EM_D);
	assign result_out.arrival_index = res_idx_q;
	assign result_out.out_left      = res_box_q[BW-1:3*CB+SB];
	assign result_out.out_top       = res_box_q[3*CB+SB-1:2*CB+SB];
	assign result_out.out_right     = res_box_q[2*CB+SB-1:CB+SB];
	assign result_out.out_bottom    = res_box_q[CB+SB-1:SB];
	assign result_out.out_score     = res_box_q[SB-1:0];
	assign result_out.kept          = res_kept_q;
	assign result_out.end_of_set    = res_end_q;
	assign result_out.overflowed    = res_ovf_q;

	// loading and emission never overlap
	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(box_in.ready && result_out.valid))
		else $error("request and result sides active together");

	// overflow only once the store is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == MAX_CNT))
		else $error("overflow flagged with free store entries");

	// last result taken returns to loading
	a_end_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.ready && result_out.end_of_set) |=> box_in.ready)
		else $error("block not reloading after end of set");

	// the pair test is started only while suppression waits on it
	a_iou_start: assert property (@(posedge clk) disable iff (!arst_n)
		iou_req.start |=> (state_q == S_SP_G))
		else $error("pair test started outside suppression");
endmodule

[rtl/bos_ram.sv]
// bos_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
module bos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/bos_iou.sv]
// bos_iou: pairwise overlap test, intersection*2^16 > threshold*union, on one
// shared registered multiplier over up to six steps. Depends on bos_pkg.
module bos_iou #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bos_pkg::iou_req_t            req,
	input  logic [4*COORD_BITS-1:0]      box_a,
	input  logic [4*COORD_BITS-1:0]      box_b,
	input  logic [bos_pkg::THRESH_BITS-1:0] thresh,
	output bos_pkg::iou_rsp_t            rsp
);
	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int MW = 2 * CB + 3;
	localparam int PW = 2 * MW;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_M1   = 7'b0000010,
		ST_M2   = 7'b0000100,
		ST_M3   = 7'b0001000,
		ST_UNI  = 7'b0010000,
		ST_THR  = 7'b0100000,
		ST_CMP  = 7'b1000000
	} step_t;

	step_t step_q;
	logic [4*CB-1:0] a_q, b_q;
	logic signed [MW-1:0] op_a, op_b, uni_q;
	logic signed [PW-1:0] p_q, inter_q, area_a_q, prod, uni_sum, lhs;
	logic [CB-1:0] xl, yt, xr, yb;
	logic signed [DW-1:0] w, h;

	function automatic logic signed [MW-1:0] sx(input logic signed [DW-1:0] v);
		sx = {{(MW-DW){v[DW-1]}}, v};
	endfunction

	function automatic logic signed [DW-1:0] dif(input logic [CB-1:0] hi, input logic [CB-1:0] lo);
		dif = $signed({1'b0, hi}) - $signed({1'b0, lo});
	endfunction

	// corner fields: {left, top, right, bottom}
	always_comb begin
		xl = (a_q[4*CB-1:3*CB] > b_q[4*CB-1:3*CB]) ? a_q[4*CB-1:3*CB] : b_q[4*CB-1:3*CB];
		yt = (a_q[3*CB-1:2*CB] > b_q[3*CB-1:2*CB]) ? a_q[3*CB-1:2*CB] : b_q[3*CB-1:2*CB];
		xr = (a_q[2*CB-1:CB] < b_q[2*CB-1:CB]) ? a_q[2*CB-1:CB] : b_q[2*CB-1:CB];
		yb = (a_q[CB-1:0] < b_q[CB-1:0]) ? a_q[CB-1:0] : b_q[CB-1:0];
		w  = dif(xr, xl);
		h  = dif(yb, yt);
		if (w[DW-1]) begin
			w = '0;
		end
		if (h[DW-1]) begin
			h = '0;
		end
	end

	always_comb begin
		op_a = sx(w);
		op_b = sx(h);
		case (step_q)
			ST_M2: begin
				op_a = sx(dif(a_q[2*CB-1:CB], a_q[4*CB-1:3*CB]));
				op_b = sx(dif(a_q[CB-1:0], a_q[3*CB-1:2*CB]));
			end
			ST_M3: begin
				op_a = sx(dif(b_q[2*CB-1:CB], b_q[4*CB-1:3*CB]));
				op_b = sx(dif(b_q[CB-1:0], b_q[3*CB-1:2*CB]));
			end
			ST_THR: begin
				op_a = {{(MW-bos_pkg::THRESH_BITS){1'b0}}, thresh};
				op_b = uni_q;
			end
			default: ;
		endcase
	end

	assign prod    = op_a * op_b;
	assign uni_sum = area_a_q + p_q - inter_q;
	assign lhs     = inter_q <<< bos_pkg::FRAC_BITS;

	always_ff @(posedge clk) begin
		p_q <= prod;
		if (req.start) begin
			a_q <= box_a;
			b_q <= box_b;
		end
		if (step_q == ST_M2) inter_q <= p_q;
		if (step_q == ST_M3) area_a_q <= p_q;
		if (step_q == ST_UNI) uni_q <= uni_sum[MW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			rsp    <= '0;
		end else begin
			rsp <= '0;
			case (step_q)
				ST_IDLE: if (req.start) step_q <= ST_M1;
				ST_M1:   step_q <= ST_M2;
				ST_M2:   step_q <= ST_M3;
				ST_M3:   step_q <= ST_UNI;
				ST_UNI:  step_q <= ST_THR;
				ST_THR: begin
					// union of zero or less never overlaps
					if (uni_q[MW-1] || uni_q == '0) begin
						rsp.done <= 1'b1;
						step_q   <= ST_IDLE;
					end else begin
						step_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					rsp.done    <= 1'b1;
					rsp.overlap <= lhs > p_q;
					step_q      <= ST_IDLE;
				end
				default: step_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[verif/tb_box_overlap_suppression_core.sv]
// tb_box_overlap_suppression_core: self-checking bench for the box overlap suppression core.
// Depends on bos_pkg, bos_if (bos_box_if, bos_res_if) and the core RTL.
module tb_box_overlap_suppression_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 64;

	typedef struct packed {
		logic [11:0] left;
		logic [11:0] top;
		logic [11:0] right;
		logic [11:0] bottom;
		logic [15:0] score;
		logic        fin;
	} box_req_t;

	typedef struct packed {
		logic [5:0]  idx;
		logic [11:0] left;
		logic [11:0] top;
		logic [11:0] right;
		logic [11:0] bottom;
		logic [15:0] score;
		logic        kept;
		logic        eos;
		logic        ovf;
	} box_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bos_pkg::THRESH_BITS-1:0] cfg_wdata = '0;

	bos_box_if #(.COORD_BITS(12), .SCORE_BITS(16)) box_ch ();
	bos_res_if #(.INDEX_BITS(6), .COORD_BITS(12), .SCORE_BITS(16)) res_ch ();

	box_overlap_suppression_core #(
		.MAX_BOXES (CAPACITY),
		.COORD_BITS(12),
		.SCORE_BITS(16)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.box_in    (box_ch.sink),
		.result_out(res_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be offered, and expected ranked results.
	box_req_t pending_boxes[$];
	box_res_t ranked_results[$];

	// Shadow of the core: current threshold, boxes of the open set, overflow.
	logic [15:0] iou_limit = bos_pkg::THRESH_RESET;
	box_req_t    open_set[$];
	bit          set_overflow = 0;

	int mismatches = 0;
	int send_idle_pct = 8;
	int recv_idle_pct = 65;
	bit hold_off = 0;
	bit box_taken = 0;
	int phase = 0;

	// Box overlap without division: inter*65536 > limit*union.
	// Areas are signed, so a box inverted on one axis has a negative area; a union
	// of zero or less never overlaps.
	function automatic bit boxes_overlap(box_req_t a, box_req_t b, logic [15:0] lim);
		longint xl, yt, xr, yb, w, h, inter, area_a, area_b, uni;
		xl = (a.left > b.left) ? a.left : b.left;
		yt = (a.top > b.top) ? a.top : b.top;
		xr = (a.right < b.right) ? a.right : b.right;
		yb = (a.bottom < b.bottom) ? a.bottom : b.bottom;
		w = xr - xl;
		h = yb - yt;
		if (w < 0) w = 0;
		if (h < 0) h = 0;
		inter = w * h;
		area_a = (longint'(a.right) - longint'(a.left)) * (longint'(a.bottom) - longint'(a.top));
		area_b = (longint'(b.right) - longint'(b.left)) * (longint'(b.bottom) - longint'(b.top));
		uni = area_a + area_b - inter;
		if (uni <= 0) return 0;
		return (inter * 65536) > (longint'(lim) * uni);
	endfunction

	// Takes one accepted request; on the closing request ranks the set,
	// runs greedy suppression and queues one result per stored box.
	task automatic absorb_box(box_req_t b);
		int rank[$];
		bit keep_mark[$];
		int n, pos;
		bit keep;
		box_res_t r;
		if (open_set.size() < CAPACITY)
			open_set.insert(open_set.size(), b);
		else
			set_overflow = 1;
		if (!b.fin) return;
		n = open_set.size();
		// stable: a box goes after every box of equal or higher score
		for (int i = 0; i < n; i++) begin
			pos = rank.size();
			while (pos > 0 && open_set[rank[pos-1]].score < open_set[i].score) pos--;
			rank.insert(pos, i);
		end
		for (int i = 0; i < n; i++) begin
			keep = 1;
			for (int j = 0; j < i && keep; j++)
				if (keep_mark[j] && boxes_overlap(open_set[rank[i]], open_set[rank[j]], iou_limit))
					keep = 0;
			keep_mark.insert(keep_mark.size(), keep);
		end
		for (int i = 0; i < n; i++) begin
			r.idx    = rank[i][5:0];
			r.left   = open_set[rank[i]].left;
			r.top    = open_set[rank[i]].top;
			r.right  = open_set[rank[i]].right;
			r.bottom = open_set[rank[i]].bottom;
			r.score  = open_set[rank[i]].score;
			r.kept   = keep_mark[i];
			r.eos    = (i == n - 1);
			r.ovf    = set_overflow;
			ranked_results.insert(ranked_results.size(), r);
		end
		open_set.delete();
		set_overflow = 0;
	endtask

	// Request driver: inputs change on the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			box_ch.valid <= 1'b0;
		end else if (!box_ch.valid || box_taken) begin
			if (pending_boxes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				box_req_t b;
				b = pending_boxes.pop_front();
				box_ch.valid      <= 1'b1;
				box_ch.box_left   <= b.left;
				box_ch.box_top    <= b.top;
				box_ch.box_right  <= b.right;
				box_ch.box_bottom <= b.bottom;
				box_ch.score      <= b.score;
				box_ch.final_box  <= b.fin;
			end else begin
				box_ch.valid <= 1'b0;
			end
		end
	end

	initial begin
		box_ch.valid = 1'b0;
		box_ch.box_left = '0;
		box_ch.box_top = '0;
		box_ch.box_right = '0;
		box_ch.box_bottom = '0;
		box_ch.score = '0;
		box_ch.final_box = 1'b0;
		res_ch.ready = 1'b0;
	end

	// Result-side backpressure; hold_off forces a long stall.
	always @(negedge clk)
		res_ch.ready <= arst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);

	// Request monitor: feeds the shadow model on each handshake.
	always @(posedge clk) begin
		box_taken <= box_ch.valid && box_ch.ready;
		if (arst_n && box_ch.valid && box_ch.ready)
			absorb_box({box_ch.box_left, box_ch.box_top, box_ch.box_right,
				box_ch.box_bottom, box_ch.score, box_ch.final_box});
	end

	// Result monitor: every result must match the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			box_res_t got;
			got = {res_ch.arrival_index, res_ch.out_left, res_ch.out_top, res_ch.out_right,
				res_ch.out_bottom, res_ch.out_score, res_ch.kept, res_ch.end_of_set,
				res_ch.overflowed};
			if (ranked_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", got);
			end else begin
				box_res_t want;
				want = ranked_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	function automatic logic [11:0] clamp12(int v);
		return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : v[11:0];
	endfunction

	task automatic queue_box(int l, int t, int r, int b, int s, bit f);
		box_req_t x;
		x.left = l[11:0];
		x.top = t[11:0];
		x.right = r[11:0];
		x.bottom = b[11:0];
		x.score = s[15:0];
		x.fin = f;
		pending_boxes.insert(pending_boxes.size(), x);
	endtask

	// One set of n boxes, mostly clustered so suppression actually happens;
	// a few are fully random or inverted, scores often collide for ties.
	task automatic queue_set(int n);
		int cx, cy, w, h, l, t, r, b, s, tmp;
		cx = $urandom_range(4095);
		cy = $urandom_range(4095);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: begin
					l = $urandom_range(4095); t = $urandom_range(4095);
					r = $urandom_range(4095); b = $urandom_range(4095);
				end
				1: begin
					w = $urandom_range(300); h = $urandom_range(300);
					l = clamp12(cx + w); r = clamp12(cx - w);
					t = clamp12(cy - h); b = clamp12(cy + h);
					if ($urandom_range(1)) begin tmp = t; t = b; b = tmp; end
				end
				default: begin
					w = $urandom_range(40, 400); h = $urandom_range(40, 400);
					l = clamp12(cx - w + $urandom_range(60) - 30);
					t = clamp12(cy - h + $urandom_range(60) - 30);
					r = clamp12(cx + w + $urandom_range(60) - 30);
					b = clamp12(cy + h + $urandom_range(60) - 30);
				end
			endcase
			case ($urandom_range(3))
				0: s = $urandom_range(3) * 16384 + ($urandom_range(1) ? 16383 : 0);
				default: s = $urandom_range(65535);
			endcase
			queue_box(l, t, r, b, s, i == n - 1);
		end
	endtask

	// Block is idle once every request went in and every result came out.
	task automatic wait_idle();
		while (pending_boxes.size() > 0 || box_ch.valid || ranked_results.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_threshold(logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		iou_limit = v;
	endtask

	// Long receiver stall in the last phase so the core backs up its input.
	initial begin
		wait (phase == 2);
		@(posedge clk);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		int count;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset threshold: a lone box at the extremes.
		queue_box(0, 0, 4095, 4095, 65535, 1);
		// Identical and near-identical boxes with tied scores: arrival order kept, later removed.
		queue_box(100, 100, 200, 200, 30000, 0);
		queue_box(100, 100, 200, 200, 30000, 0);
		queue_box(101, 100, 200, 200, 30000, 0);
		// Inverted corners and zero-area boxes (union zero).
		queue_box(200, 200, 100, 100, 65535, 0);
		queue_box(50, 50, 50, 50, 0, 0);
		queue_box(50, 50, 50, 50, 0, 0);
		queue_box(4095, 4095, 0, 0, 1, 0);
		queue_box(2730, 1365, 2730, 1365, 43690, 1);
		wait_idle();

		// Threshold zero: any shared area suppresses.
		set_threshold(16'd0);
		queue_box(0, 0, 1000, 1000, 500, 0);
		queue_box(999, 999, 2000, 2000, 400, 0);
		queue_box(1000, 1000, 2000, 2000, 300, 0);
		queue_box(1365, 2730, 4095, 4095, 21845, 1);
		wait_idle();

		// Threshold all ones: only near-identical boxes suppress.
		set_threshold(16'hFFFF);
		queue_box(10, 10, 20, 20, 9, 0);
		queue_box(10, 10, 20, 20, 9, 0);
		queue_box(10, 10, 20, 21, 8, 1);
		wait_idle();

		// Random phases: sender lightly idle, then receiver lightly idle, then neither.
		for (int p = 0; p < 3; p++) begin
			phase = p;
			send_idle_pct = (p == 0) ? 8 : (p == 1) ? 65 : 0;
			recv_idle_pct = (p == 0) ? 65 : (p == 1) ? 8 : 0;
			set_threshold((p == 0) ? bos_pkg::THRESH_RESET :
				(p == 1) ? 16'($urandom) : 16'd16384);
			if (p == 0) queue_set(CAPACITY + 2); // overflow, closing box dropped
			count = 0;
			while (count < 30) begin
				int n;
				n = $urandom_range(1, 8);
				queue_set(n);
				count += n;
			end
			wait_idle();
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0 && ranked_results.size() == 0)
			$display("box_overlap_suppression_core verification clean");
		else
			$display("box_overlap_suppression_core verification failed");
		$finish;
	end

	initial begin
		#30ms;
		$display("box_overlap_suppression_core verification failed");
		$finish;
	end
endmodule
